[hdl/seconds_to_calendar_date_assert.svh]
// ----------------------------------------------------------------------------
// seconds_to_calendar_date assertion macros
// shared property wrappers, clocked on clk_i and quiet during reset
// ----------------------------------------------------------------------------
`ifndef SECONDS_TO_CALENDAR_DATE_ASSERT_SVH
`define SECONDS_TO_CALENDAR_DATE_ASSERT_SVH

// same-cycle implication
`define STCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STCD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/stcd_pkg.sv]
// ----------------------------------------------------------------------------
// stcd_pkg
// types, constants and helpers shared by the calendar conversion modules
// ----------------------------------------------------------------------------
package stcd_pkg;

  localparam int CNT_W     = 1;
  // steps per constant division: reciprocal multiply, then remainder
  localparam int DIV_STEPS = 2;

  localparam logic REG_BASE_YEAR = 1'b0;
  localparam logic [11:0] BASE_YEAR_RST = 12'd2000;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_MIN,
    ST_HOUR,
    ST_BASE,
    ST_YEAR,
    ST_MONTH,
    ST_PUB
  } state_e;

  typedef enum logic [3:0] {
    OP_HOLD,
    OP_LOAD_SECS,
    OP_DIV,
    OP_END_SEC,
    OP_END_MIN,
    OP_END_HOUR,
    OP_END_BASE,
    OP_YEAR_STEP,
    OP_MONTH_STEP,
    OP_PUBLISH
  } dp_op_e;

  typedef enum logic [1:0] {
    DIV_60,
    DIV_24,
    DIV_100
  } div_sel_e;

  typedef struct packed {
    dp_op_e   op;
    div_sel_e div;
  } cmd_t;

  typedef struct packed {
    logic year_fits;
    logic month_fits;
    logic month_last;
  } stat_t;

  function automatic logic [6:0] divisor(div_sel_e sel);
    logic [6:0] d;
    unique case (sel)
      DIV_60:  d = 7'd60;
      DIV_24:  d = 7'd24;
      DIV_100: d = 7'd100;
      default: d = 7'd60;
    endcase
    return d;
  endfunction

  // rounded-up reciprocals, exact for any 32-bit dividend
  // scaled by 2^37, except 2^36 for the divide by 24
  function automatic logic [31:0] recip(div_sel_e sel);
    logic [31:0] k;
    unique case (sel)
      DIV_60:  k = 32'h8888_8889;
      DIV_24:  k = 32'hAAAA_AAAB;
      DIV_100: k = 32'h51EB_851F;
      default: k = 32'h8888_8889;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] month, logic leap);
    logic [4:0] n;
    unique case (month)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

[hdl/seconds_to_calendar_date.sv]
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// elapsed seconds since 1 january of base_year to gregorian date and time
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// input     in         in_valid_i / in_ready_o   elapsed_seconds_i
// result    out        out_valid_o / out_ready_i year_o .. day_count_o
// config    in         apb psel/penable/pwrite   paddr, pwdata, prdata
//
// an item holds the block through four constant divisions, a year walk of at
// most MAX_YEAR_SPAN years and a month walk, one exit state per walk, publish
// and the accepting idle state
// in_ready_o is high only between items; a finished result waits in the
// output register, so the next item is taken while out_ready_i is low
// reset clears the sequencer and sets base_year to 2000; no clearing pass
// ----------------------------------------------------------------------------
module seconds_to_calendar_date #(
  parameter int MAX_YEAR_SPAN = 136
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] elapsed_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [12:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [15:0] day_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0]     base_year_q;
  logic            cfg_wr;
  stcd_pkg::cmd_t  cmd;
  stcd_pkg::stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_year_q <= stcd_pkg::BASE_YEAR_RST;
    end else if (cfg_wr && (paddr[2] == stcd_pkg::REG_BASE_YEAR)) begin
      base_year_q <= pwdata[11:0];
    end
  end

  assign prdata = (paddr[2] == stcd_pkg::REG_BASE_YEAR) ? {20'd0, base_year_q} : '0;

  stcd_ctrl #(
    .MAX_YEAR_SPAN (MAX_YEAR_SPAN)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  stcd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .elapsed_seconds_i (elapsed_seconds_i),
    .base_year_i       (base_year_q),
    .year_o            (year_o),
    .month_o           (month_o),
    .day_of_month_o    (day_of_month_o),
    .hour_o            (hour_o),
    .minute_o          (minute_o),
    .second_o          (second_o),
    .day_count_o       (day_count_o)
  );

endmodule

[hdl/stcd_dp.sv]
// ----------------------------------------------------------------------------
// stcd_dp
// datapath: reciprocal constant divider, year and month walk, result register
// ----------------------------------------------------------------------------
`include "seconds_to_calendar_date_assert.svh"

module stcd_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stcd_pkg::cmd_t      cmd_i,
  output stcd_pkg::stat_t     stat_o,
  input  logic [31:0]         elapsed_seconds_i,
  input  logic [11:0]         base_year_i,
  output logic [12:0]         year_o,
  output logic [3:0]          month_o,
  output logic [4:0]          day_of_month_o,
  output logic [4:0]          hour_o,
  output logic [5:0]          minute_o,
  output logic [5:0]          second_o,
  output logic [15:0]         day_count_o
);

  logic [31:0] q_q, q_d;
  logic [31:0] quo_q, quo_d;
  logic [5:0]  second_q, second_d;
  logic [5:0]  minute_q, minute_d;
  logic [4:0]  hour_q, hour_d;
  logic [15:0] days_q, days_d;
  logic [15:0] rem_q, rem_d;
  logic [12:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [6:0]  c100_q, c100_d;
  logic [1:0]  c4h_q, c4h_d;

  logic [12:0] o_year_q, o_year_d;
  logic [3:0]  o_month_q, o_month_d;
  logic [4:0]  o_dom_q, o_dom_d;
  logic [4:0]  o_hour_q, o_hour_d;
  logic [5:0]  o_minute_q, o_minute_d;
  logic [5:0]  o_second_q, o_second_d;
  logic [15:0] o_dcount_q, o_dcount_d;

  logic [6:0]  dv;
  logic [31:0] mul_k;
  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] back;
  logic [31:0] remv;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  // quotient from the registered dividend, remainder in the following cycle from the registered quotient
  assign dv    = stcd_pkg::divisor(cmd_i.div);
  assign mul_k = stcd_pkg::recip(cmd_i.div);
  assign prod  = {32'd0, q_q} * {32'd0, mul_k};
  assign quo   = (cmd_i.div == stcd_pkg::DIV_24) ? {4'd0, prod[63:36]}
                                                 : {5'd0, prod[63:37]};
  assign back  = quo_q * {25'd0, dv};
  assign remv  = q_q - back;

  // a century year is leap only when the century count is a multiple of four
  assign leap = (c100_q == 7'd0) ? (c4h_q == 2'd0) : (year_q[1:0] == 2'b00);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = stcd_pkg::month_days(month_q, leap);

  assign stat_o.year_fits  = rem_q >= {7'd0, ylen};
  assign stat_o.month_fits = rem_q >= {11'd0, mlen};
  assign stat_o.month_last = month_q == 4'd12;

  always_comb begin
    q_d        = q_q;
    quo_d      = quo_q;
    second_d   = second_q;
    minute_d   = minute_q;
    hour_d     = hour_q;
    days_d     = days_q;
    rem_d      = rem_q;
    year_d     = year_q;
    month_d    = month_q;
    c100_d     = c100_q;
    c4h_d      = c4h_q;
    o_year_d   = o_year_q;
    o_month_d  = o_month_q;
    o_dom_d    = o_dom_q;
    o_hour_d   = o_hour_q;
    o_minute_d = o_minute_q;
    o_second_d = o_second_q;
    o_dcount_d = o_dcount_q;
    unique case (cmd_i.op)
      stcd_pkg::OP_HOLD: begin
      end
      stcd_pkg::OP_LOAD_SECS: begin
        q_d = elapsed_seconds_i;
      end
      stcd_pkg::OP_DIV: begin
        quo_d = quo;
      end
      stcd_pkg::OP_END_SEC: begin
        second_d = remv[5:0];
        q_d      = quo_q;
      end
      stcd_pkg::OP_END_MIN: begin
        minute_d = remv[5:0];
        q_d      = quo_q;
      end
      stcd_pkg::OP_END_HOUR: begin
        hour_d = remv[4:0];
        days_d = quo_q[15:0];
        rem_d  = quo_q[15:0];
        q_d    = {20'd0, base_year_i};
      end
      stcd_pkg::OP_END_BASE: begin
        // remainder and quotient of base_year by 100 seed the leap counters
        c100_d  = remv[6:0];
        c4h_d   = quo_q[1:0];
        year_d  = {1'b0, base_year_i};
        month_d = 4'd1;
      end
      stcd_pkg::OP_YEAR_STEP: begin
        rem_d  = rem_q - {7'd0, ylen};
        year_d = year_q + 13'd1;
        if (c100_q == 7'd99) begin
          c100_d = '0;
          c4h_d  = c4h_q + 2'd1;
        end else begin
          c100_d = c100_q + 7'd1;
        end
      end
      stcd_pkg::OP_MONTH_STEP: begin
        rem_d   = rem_q - {11'd0, mlen};
        month_d = month_q + 4'd1;
      end
      stcd_pkg::OP_PUBLISH: begin
        o_year_d   = year_q;
        o_month_d  = month_q;
        o_dom_d    = (rem_q >= 16'd31) ? 5'd31 : (rem_q[4:0] + 5'd1);
        o_hour_d   = hour_q;
        o_minute_d = minute_q;
        o_second_d = second_q;
        o_dcount_d = days_q + 16'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      month_q <= 4'd1;
      c100_q  <= '0;
      c4h_q   <= '0;
    end else begin
      month_q <= month_d;
      c100_q  <= c100_d;
      c4h_q   <= c4h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q        <= q_d;
    quo_q      <= quo_d;
    second_q   <= second_d;
    minute_q   <= minute_d;
    hour_q     <= hour_d;
    days_q     <= days_d;
    rem_q      <= rem_d;
    year_q     <= year_d;
    o_year_q   <= o_year_d;
    o_month_q  <= o_month_d;
    o_dom_q    <= o_dom_d;
    o_hour_q   <= o_hour_d;
    o_minute_q <= o_minute_d;
    o_second_q <= o_second_d;
    o_dcount_q <= o_dcount_d;
  end

  assign year_o         = o_year_q;
  assign month_o        = o_month_q;
  assign day_of_month_o = o_dom_q;
  assign hour_o         = o_hour_q;
  assign minute_o       = o_minute_q;
  assign second_o       = o_second_q;
  assign day_count_o    = o_dcount_q;

  `STCD_ASSERT_IMP(a_month_range, 1'b1, (month_q >= 4'd1) && (month_q <= 4'd12), "month out of range")
  `STCD_ASSERT_IMP(a_century_range, 1'b1, c100_q < 7'd100, "century counter out of range")

endmodule

[hdl/stcd_ctrl.sv]
// ----------------------------------------------------------------------------
// stcd_ctrl
// sequencer: division phases, year walk, month walk, result handoff
// ----------------------------------------------------------------------------
`include "seconds_to_calendar_date_assert.svh"

module stcd_ctrl #(
  parameter int MAX_YEAR_SPAN = 136
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  stcd_pkg::stat_t  stat_i,
  output stcd_pkg::cmd_t   cmd_o
);

  localparam int YW = $clog2(MAX_YEAR_SPAN + 1);

  stcd_pkg::state_e state_q, state_d;
  stcd_pkg::cnt_t   cnt_q, cnt_d;
  logic [YW-1:0]    ystep_q, ystep_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stcd_pkg::ST_IDLE;
      cnt_q       <= '0;
      ystep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ystep_q     <= ystep_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ystep_d     = ystep_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = stcd_pkg::OP_HOLD;
    cmd_o.div   = stcd_pkg::DIV_60;
    unique case (state_q)
      stcd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = stcd_pkg::OP_LOAD_SECS;
          cnt_d    = '0;
          state_d  = stcd_pkg::ST_SEC;
        end
      end
      stcd_pkg::ST_SEC: begin
        if (cnt_q == stcd_pkg::CNT_W'(stcd_pkg::DIV_STEPS - 1)) begin
          cmd_o.op = stcd_pkg::OP_END_SEC;
          cnt_d    = '0;
          state_d  = stcd_pkg::ST_MIN;
        end else begin
          cmd_o.op = stcd_pkg::OP_DIV;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      stcd_pkg::ST_MIN: begin
        if (cnt_q == stcd_pkg::CNT_W'(stcd_pkg::DIV_STEPS - 1)) begin
          cmd_o.op = stcd_pkg::OP_END_MIN;
          cnt_d    = '0;
          state_d  = stcd_pkg::ST_HOUR;
        end else begin
          cmd_o.op = stcd_pkg::OP_DIV;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      stcd_pkg::ST_HOUR: begin
        cmd_o.div = stcd_pkg::DIV_24;
        if (cnt_q == stcd_pkg::CNT_W'(stcd_pkg::DIV_STEPS - 1)) begin
          cmd_o.op = stcd_pkg::OP_END_HOUR;
          cnt_d    = '0;
          state_d  = stcd_pkg::ST_BASE;
        end else begin
          cmd_o.op = stcd_pkg::OP_DIV;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      stcd_pkg::ST_BASE: begin
        cmd_o.div = stcd_pkg::DIV_100;
        if (cnt_q == stcd_pkg::CNT_W'(stcd_pkg::DIV_STEPS - 1)) begin
          cmd_o.op = stcd_pkg::OP_END_BASE;
          cnt_d    = '0;
          ystep_d  = '0;
          state_d  = stcd_pkg::ST_YEAR;
        end else begin
          cmd_o.op = stcd_pkg::OP_DIV;
          cnt_d    = cnt_q + 1'b1;
        end
      end
      stcd_pkg::ST_YEAR: begin
        if ((ystep_q == YW'(MAX_YEAR_SPAN)) || !stat_i.year_fits) begin
          state_d = stcd_pkg::ST_MONTH;
        end else begin
          cmd_o.op = stcd_pkg::OP_YEAR_STEP;
          ystep_d  = ystep_q + 1'b1;
        end
      end
      stcd_pkg::ST_MONTH: begin
        if (stat_i.month_last || !stat_i.month_fits) begin
          state_d = stcd_pkg::ST_PUB;
        end else begin
          cmd_o.op = stcd_pkg::OP_MONTH_STEP;
        end
      end
      stcd_pkg::ST_PUB: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = stcd_pkg::OP_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = stcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stcd_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready_o  = state_q == stcd_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;

  `STCD_ASSERT_IMP(a_publish_free, cmd_o.op == stcd_pkg::OP_PUBLISH, !out_valid_q || out_ready_i, "result overwritten before taken")
  `STCD_ASSERT_IMP(a_span_bound, 1'b1, ystep_q <= YW'(MAX_YEAR_SPAN), "year walk past its bound")
  `STCD_ASSERT_NXT(a_accept_starts, in_valid_i && in_ready_o, state_q == stcd_pkg::ST_SEC, "accepted item did not start")
  `STCD_ASSERT_NXT(a_publish_valid, cmd_o.op == stcd_pkg::OP_PUBLISH, out_valid_q, "published result not valid")

endmodule
